FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define GPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Antecedent holds -> consequent holds in the next cycle.
`define GPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

FILE: src/gpht_pkg.sv
// Package for the grouped-probe hash table: widths, codes, markers and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gpht_pkg;

  localparam int GROUP_SLOTS_DEF = 16;
  localparam int GROUP_COUNT_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 48;
  localparam int HASH_W   = 56;
  localparam int HOLDER_W = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int TAG_W    = 7;
  localparam int CTRL_W   = 8;

  localparam logic [CTRL_W-1:0]  CTRL_EMPTY    = 8'h80;
  localparam logic [CTRL_W-1:0]  CTRL_DELETED  = 8'hFE;
  localparam logic [COUNT_W-1:0] MAX_OCC_RESET = 11'd896;
  localparam logic [COUNT_W-1:0] LIVE_LIMIT    = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    eval;
    logic    advance;
    logic    hold_rd;
    logic    upd_wr;
    logic    rem_wr;
    logic    ins_wr;
    logic    clr_wr;
    logic    out_load;
    status_e res;
  } gpht_cmd_t;

  typedef struct packed {
    func_e func;
    logic  key_zero;
    logic  full;
    logic  home_done;
    logic  hit;
    logic  has_empty;
    logic  del_any;
    logic  last_probe;
    logic  clr_last;
    logic  live_zero;
    logic  out_busy;
  } gpht_sts_t;

endpackage

`default_nettype wire

FILE: src/gpht_intf.sv
// Channel interfaces of the grouped-probe hash table: request, response and
// configuration write. Depends on gpht_pkg.
`default_nettype none

interface gpht_req_if;
  import gpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_W-1:0]    key;
  logic [HASH_W-1:0]   hash;
  logic [KEY_W-1:0]    new_key;
  logic [HOLDER_W-1:0] holder_in;
  modport source (output valid, func, key, hash, new_key, holder_in, input ready);
  modport sink   (input valid, func, key, hash, new_key, holder_in, output ready);
endinterface

interface gpht_rsp_if;
  import gpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [HOLDER_W-1:0] holder_out;
  logic [COUNT_W-1:0]  live_count;
  modport source (output valid, status, slot, holder_out, live_count, input ready);
  modport sink   (input valid, status, slot, holder_out, live_count, output ready);
endinterface

interface gpht_cfg_if;
  import gpht_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/gpht_dp.sv
// Datapath: control-byte, key and holder memories, group match logic,
// home-group reduction, counters and the result register. Depends on gpht_pkg.
`default_nettype none

module gpht_dp #(
  parameter int GROUP_SLOTS = gpht_pkg::GROUP_SLOTS_DEF,
  parameter int GROUP_COUNT = gpht_pkg::GROUP_COUNT_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  gpht_pkg::gpht_cmd_t            cmd_i,
  output gpht_pkg::gpht_sts_t            sts_o,
  input  wire [gpht_pkg::FUNC_W-1:0]     func_i,
  input  wire [gpht_pkg::KEY_W-1:0]      key_i,
  input  wire [gpht_pkg::HASH_W-1:0]     hash_i,
  input  wire [gpht_pkg::KEY_W-1:0]      new_key_i,
  input  wire [gpht_pkg::HOLDER_W-1:0]   holder_in_i,
  input  wire                            cfg_valid_i,
  input  wire [gpht_pkg::COUNT_W-1:0]    cfg_data_i,
  input  wire                            out_ready_i,
  output logic                           out_valid_o,
  output logic [gpht_pkg::STATUS_W-1:0]  status_o,
  output logic [gpht_pkg::SLOT_W-1:0]    slot_o,
  output logic [gpht_pkg::HOLDER_W-1:0]  holder_out_o,
  output logic [gpht_pkg::COUNT_W-1:0]   live_count_o
);
  import gpht_pkg::*;

  localparam int GW       = $clog2(GROUP_COUNT);
  localparam int LW       = $clog2(GROUP_SLOTS);
  localparam int IW       = GW + LW;
  localparam bit IS_POW2  = (GROUP_COUNT & (GROUP_COUNT - 1)) == 0;
  localparam int HB       = HASH_W - TAG_W;
  localparam int MOD_STEP = 7;
  localparam int MOD_CYC  = (HB + MOD_STEP - 1) / MOD_STEP;
  localparam int MB       = MOD_CYC * MOD_STEP;
  localparam int CW       = $clog2(MOD_CYC + 1);

  // memories
  logic [CTRL_W-1:0]   ctrl_mem   [GROUP_COUNT][GROUP_SLOTS];
  logic [KEY_W-1:0]    key_mem    [GROUP_COUNT][GROUP_SLOTS];
  logic [HOLDER_W-1:0] holder_mem [GROUP_COUNT][GROUP_SLOTS];

  // latched item
  func_e               func_q;
  logic [KEY_W-1:0]    key_q, new_key_q;
  logic [TAG_W-1:0]    tag_q;
  logic [HOLDER_W-1:0] holder_q;

  logic [CTRL_W-1:0]   ctrl_row_q [GROUP_SLOTS];
  logic [KEY_W-1:0]    key_row_q  [GROUP_SLOTS];
  logic [HOLDER_W-1:0] hold_q;

  logic [GW-1:0] grp_q, probe_q, clr_q, slot_grp_q, del_grp_q, grp_inc;
  logic [LW-1:0] slot_lane_q, del_lane_q;
  logic          del_found_q;
  logic [CW-1:0] mod_cnt_q;
  logic [MB-1:0] mod_bits_q, mod_bits;
  logic [GW-1:0] mod_r;
  logic [GW:0]   mod_t;

  logic [COUNT_W-1:0] live_q, max_occ_q;

  logic                out_valid_q;
  status_e             status_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [HOLDER_W-1:0] holder_out_q;
  logic [COUNT_W-1:0]  live_out_q;

  logic [GROUP_SLOTS-1:0] hit_v, emp_v, del_v;
  logic [LW-1:0]          first_hit, first_emp, first_del;

  logic [GROUP_SLOTS-1:0] wr_en;
  logic [GW-1:0]          wr_row;
  logic [CTRL_W-1:0]      wr_data;

  logic [IW-1:0]        slot_idx;
  logic [IW+SLOT_W-1:0] slot_ext;

  // home group: remainder of hash[55:7] by the group count, MOD_STEP bits a cycle
  always_comb begin
    mod_r    = grp_q;
    mod_bits = mod_bits_q;
    mod_t    = '0;
    for (int s = 0; s < MOD_STEP; s++) begin
      mod_t    = {mod_r, mod_bits[MB-1]};
      mod_bits = mod_bits << 1;
      if (mod_t >= (GW+1)'(GROUP_COUNT)) mod_t = mod_t - (GW+1)'(GROUP_COUNT);
      mod_r = mod_t[GW-1:0];
    end
  end

  assign grp_inc = (grp_q == GW'(GROUP_COUNT - 1)) ? '0 : grp_q + 1'b1;

  // match vectors over the registered group
  always_comb begin
    for (int l = 0; l < GROUP_SLOTS; l++) begin
      hit_v[l] = (ctrl_row_q[l] == {1'b0, tag_q}) && (key_row_q[l] == key_q);
      emp_v[l] = ctrl_row_q[l] == CTRL_EMPTY;
      del_v[l] = ctrl_row_q[l] == CTRL_DELETED;
    end
    first_hit = '0;
    first_emp = '0;
    first_del = '0;
    for (int l = GROUP_SLOTS - 1; l >= 0; l--) begin
      if (hit_v[l]) first_hit = LW'(l);
      if (emp_v[l]) first_emp = LW'(l);
      if (del_v[l]) first_del = LW'(l);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q   <= '0;
      del_found_q <= 1'b0;
      probe_q     <= '0;
      clr_q       <= '0;
      live_q      <= '0;
      max_occ_q   <= MAX_OCC_RESET;
      out_valid_q <= 1'b0;
      live_out_q  <= '0;
    end else begin
      if (cfg_valid_i) max_occ_q <= cfg_data_i;

      if (cmd_i.load) begin
        mod_cnt_q   <= IS_POW2 ? '0 : CW'(MOD_CYC);
        del_found_q <= 1'b0;
        probe_q     <= '0;
      end else if (mod_cnt_q != '0) begin
        mod_cnt_q <= mod_cnt_q - 1'b1;
      end

      if (cmd_i.eval && !del_found_q && (|del_v)) del_found_q <= 1'b1;
      if (cmd_i.advance) probe_q <= probe_q + 1'b1;

      if (cmd_i.clr_wr) clr_q <= (clr_q == GW'(GROUP_COUNT - 1)) ? '0 : clr_q + 1'b1;

      if (cmd_i.ins_wr)      live_q <= live_q + 1'b1;
      else if (cmd_i.rem_wr) live_q <= live_q - 1'b1;

      // live count is captured with the beat so it holds while the beat waits
      if (cmd_i.out_load) live_out_q <= live_q;

      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_e'(func_i);
      key_q      <= key_i;
      new_key_q  <= new_key_i;
      tag_q      <= hash_i[TAG_W-1:0];
      holder_q   <= holder_in_i;
      mod_bits_q <= MB'(hash_i[HASH_W-1:TAG_W]);
      grp_q      <= IS_POW2 ? hash_i[TAG_W +: GW] : '0;
    end else if (mod_cnt_q != '0) begin
      mod_bits_q <= mod_bits;
      grp_q      <= mod_r;
    end else if (cmd_i.advance) begin
      grp_q <= grp_inc;
    end

    if (cmd_i.rd) begin
      ctrl_row_q <= ctrl_mem[grp_q];
      key_row_q  <= key_mem[grp_q];
    end

    if (cmd_i.eval) begin
      if (!del_found_q && (|del_v)) begin
        del_grp_q  <= grp_q;
        del_lane_q <= first_del;
      end
      if (|hit_v) begin
        slot_grp_q  <= grp_q;
        slot_lane_q <= first_hit;
      end else if (del_found_q) begin
        slot_grp_q  <= del_grp_q;
        slot_lane_q <= del_lane_q;
      end else if (|del_v) begin
        slot_grp_q  <= grp_q;
        slot_lane_q <= first_del;
      end else begin
        slot_grp_q  <= grp_q;
        slot_lane_q <= first_emp;
      end
    end

    if (cmd_i.hold_rd) hold_q <= holder_mem[slot_grp_q][slot_lane_q];

    if (cmd_i.out_load) begin
      status_q     <= cmd_i.res;
      slot_q       <= (cmd_i.res == ST_FOUND || cmd_i.res == ST_INSERTED) ?
                      slot_ext[SLOT_W-1:0] : '0;
      holder_out_q <= (cmd_i.res == ST_FOUND)    ? hold_q :
                      (cmd_i.res == ST_INSERTED) ? holder_q : '0;
    end
  end

  // control-byte write port: one row, per-lane enables
  always_comb begin
    wr_row  = cmd_i.clr_wr ? clr_q : slot_grp_q;
    wr_data = cmd_i.clr_wr ? CTRL_EMPTY :
              cmd_i.ins_wr ? {1'b0, tag_q} : CTRL_DELETED;
    for (int l = 0; l < GROUP_SLOTS; l++) begin
      wr_en[l] = cmd_i.clr_wr ||
                 ((cmd_i.ins_wr || cmd_i.rem_wr) && (slot_lane_q == LW'(l)));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < GROUP_SLOTS; l++) begin
      if (wr_en[l]) ctrl_mem[wr_row][l] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr)      key_mem[slot_grp_q][slot_lane_q] <= key_q;
    else if (cmd_i.upd_wr) key_mem[slot_grp_q][slot_lane_q] <= new_key_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) holder_mem[slot_grp_q][slot_lane_q] <= holder_q;
  end

  assign slot_idx = IW'(slot_grp_q) * IW'(GROUP_SLOTS) + IW'(slot_lane_q);
  assign slot_ext = (IW+SLOT_W)'(slot_idx);

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.key_zero   = key_q == '0;
    sts_o.full       = live_q >= max_occ_q;
    sts_o.home_done  = mod_cnt_q == '0;
    sts_o.hit        = |hit_v;
    sts_o.has_empty  = |emp_v;
    sts_o.del_any    = del_found_q || (|del_v);
    sts_o.last_probe = probe_q == GW'(GROUP_COUNT - 1);
    sts_o.clr_last   = clr_q == GW'(GROUP_COUNT - 1);
    sts_o.live_zero  = live_q == '0;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign holder_out_o = holder_out_q;
  assign live_count_o = live_out_q;

endmodule

`default_nettype wire

FILE: src/gpht_ctrl.sv
// Controller: sequences clear sweep, home-group reduction, group probing,
// holder read and table writes. Depends on gpht_pkg.
`default_nettype none

module gpht_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  gpht_pkg::gpht_sts_t sts_i,
  output gpht_pkg::gpht_cmd_t cmd_o
);
  import gpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HOME, S_READ, S_CHECK, S_HOLD, S_INS, S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    cmd_o.res  = res_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HOME;
        end
      end
      S_HOME: begin
        if (sts_i.home_done) begin
          if ((sts_i.func == FUNC_LOOKUP || sts_i.func == FUNC_UPDATE) && sts_i.key_zero) begin
            res_d   = ST_MISS;
            state_d = S_DONE;
          end else if (sts_i.func == FUNC_INSERT && sts_i.full) begin
            res_d   = ST_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.eval = 1'b1;
        if (sts_i.hit) begin
          res_d   = ST_FOUND;
          state_d = S_HOLD;
        end else if (sts_i.has_empty || sts_i.last_probe) begin
          if (sts_i.func == FUNC_INSERT && (sts_i.del_any || sts_i.has_empty)) begin
            res_d   = ST_INSERTED;
            state_d = S_INS;
          end else begin
            res_d   = (sts_i.func == FUNC_INSERT) ? ST_FULL : ST_MISS;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      S_HOLD: begin
        cmd_o.hold_rd = 1'b1;
        cmd_o.upd_wr  = sts_i.func == FUNC_UPDATE;
        cmd_o.rem_wr  = sts_i.func == FUNC_REMOVE;
        state_d       = S_DONE;
      end
      S_INS: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          // last live entry removed: sweep every group back to empty
          if (sts_i.func == FUNC_REMOVE && res_q == ST_FOUND && sts_i.live_zero)
            state_d = S_CLEAR;
          else
            state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= ST_MISS;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/grouped_probe_hash_table_unit.sv
// Grouped-probe hash table. One item at a time: accept, home-group reduction,
// then per probed group a memory read and a match, then a holder read or a
// table write, then the result. The result register frees the request side.
// Reset clears control state, then sweeps every group, marking all control
// bytes empty; the same sweep follows removal of the last live entry.
`default_nettype none

module grouped_probe_hash_table_unit #(
  parameter int GROUP_SLOTS = gpht_pkg::GROUP_SLOTS_DEF,
  parameter int GROUP_COUNT = gpht_pkg::GROUP_COUNT_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  gpht_req_if.sink    req_i,
  gpht_rsp_if.source  rsp_o,
  gpht_cfg_if.sink    cfg_i
);
  import gpht_pkg::*;

  gpht_cmd_t cmd;
  gpht_sts_t sts;

  assign cfg_i.ready = 1'b1;

  gpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpht_dp #(
    .GROUP_SLOTS (GROUP_SLOTS),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (req_i.func),
    .key_i        (req_i.key),
    .hash_i       (req_i.hash),
    .new_key_i    (req_i.new_key),
    .holder_in_i  (req_i.holder_in),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .slot_o       (rsp_o.slot),
    .holder_out_o (rsp_o.holder_out),
    .live_count_o (rsp_o.live_count)
  );

endmodule

`default_nettype wire

FILE: src/gpht_checker.sv
// Port-level checker for the grouped-probe hash table, bound to the top level.
// Depends on gpht_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gpht_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           out_valid_i,
  input wire                           out_ready_i,
  input wire [gpht_pkg::STATUS_W-1:0]  status_i,
  input wire [gpht_pkg::SLOT_W-1:0]    slot_i,
  input wire [gpht_pkg::HOLDER_W-1:0]  holder_i,
  input wire [gpht_pkg::COUNT_W-1:0]   live_i
);
  import gpht_pkg::*;

  `GPHT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(slot_i) && $stable(holder_i))

  `GPHT_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_i && (status_i == ST_MISS || status_i == ST_FULL), slot_i == '0 && holder_i == '0)

  `GPHT_ASSERT_NOW(a_live_cap, clk_i, rst_ni, out_valid_i, live_i <= LIVE_LIMIT)

  `GPHT_ASSERT_NOW(a_ins_live, clk_i, rst_ni, out_valid_i && status_i == ST_INSERTED, live_i != '0)

endmodule

bind grouped_probe_hash_table_unit gpht_checker u_gpht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .slot_i      (rsp_o.slot),
  .holder_i    (rsp_o.holder_out),
  .live_i      (rsp_o.live_count)
);

`default_nettype wire

FILE: test/grouped_probe_hash_table_unit_tb.sv
// Testbench for grouped_probe_hash_table_unit: directed and random table traffic,
// checked beat by beat against a behavioral table model. Depends on gpht_pkg, gpht_intf.
`timescale 1ns / 1ps

module grouped_probe_hash_table_unit_tb;
  import gpht_pkg::*;

  localparam int NSLOT  = GROUP_SLOTS_DEF * GROUP_COUNT_DEF;
  localparam int NGROUP = GROUP_COUNT_DEF;
  localparam int LIMIT  = 2000000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [HOLDER_W-1:0] holder;
    logic [COUNT_W-1:0]  live;
  } table_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gpht_req_if req_if ();
  gpht_rsp_if rsp_if ();
  gpht_cfg_if cfg_if ();

  grouped_probe_hash_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model state
  logic [CTRL_W-1:0]   ctrl_mem [NSLOT];
  logic [KEY_W-1:0]    key_mem [NSLOT];
  logic [HOLDER_W-1:0] hold_mem [NSLOT];
  logic [COUNT_W-1:0]  live_cnt;
  logic [COUNT_W-1:0]  tomb_cnt;
  logic [COUNT_W-1:0]  occ_limit;

  // Keys known to be live, with their hashes, to steer random traffic
  logic [KEY_W-1:0]  live_keys [$];
  logic [HASH_W-1:0] live_hashes [$];

  table_rsp_t expected_rsps [$];
  int errors = 0;
  int cycles = 0;
  bit rsp_stall_en = 1'b1;
  bit req_idle_en = 1'b1;

  function automatic int find_entry(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h);
    int g;
    bit has_empty;
    g = int'((h >> 7) % NGROUP);
    for (int p = 0; p < NGROUP; p++) begin
      has_empty = 1'b0;
      for (int i = 0; i < GROUP_SLOTS_DEF; i++) begin
        int s;
        s = g * GROUP_SLOTS_DEF + i;
        if (ctrl_mem[s] == {1'b0, h[TAG_W-1:0]} && key_mem[s] == k) return s;
        if (ctrl_mem[s] == CTRL_EMPTY) has_empty = 1'b1;
      end
      if (has_empty) return -1;
      g = (g + 1) % NGROUP;
    end
    return -1;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) ctrl_mem[i] = CTRL_EMPTY;
    tomb_cnt = '0;
  endfunction

  function automatic table_rsp_t predict_table(func_e f, logic [KEY_W-1:0] k,
                                               logic [HASH_W-1:0] h, logic [KEY_W-1:0] nk,
                                               logic [HOLDER_W-1:0] hin);
    table_rsp_t r;
    int s;
    r = '0;
    r.status = ST_MISS;
    case (f)
      FUNC_LOOKUP, FUNC_UPDATE: begin
        s = (k == '0) ? -1 : find_entry(k, h);
        if (s >= 0) begin
          r.status = ST_FOUND;
          r.slot = s[SLOT_W-1:0];
          r.holder = hold_mem[s];
          if (f == FUNC_UPDATE) key_mem[s] = nk;
        end
      end
      FUNC_REMOVE: begin
        s = find_entry(k, h);
        if (s >= 0) begin
          r.status = ST_FOUND;
          r.slot = s[SLOT_W-1:0];
          r.holder = hold_mem[s];
          ctrl_mem[s] = CTRL_DELETED;
          key_mem[s] = '0;
          hold_mem[s] = '0;
          live_cnt = live_cnt - 1'b1;
          tomb_cnt = tomb_cnt + 1'b1;
          if (live_cnt == '0) clear_table();
        end
      end
      default: begin
        int g, first_del, target;
        bit done;
        r.status = ST_FULL;
        if (live_cnt < occ_limit) begin
          g = int'((h >> 7) % NGROUP);
          first_del = -1;
          target = -1;
          done = 1'b0;
          for (int p = 0; p < NGROUP && !done; p++) begin
            int e;
            e = -1;
            for (int i = 0; i < GROUP_SLOTS_DEF && !done; i++) begin
              s = g * GROUP_SLOTS_DEF + i;
              if (ctrl_mem[s] == {1'b0, h[TAG_W-1:0]} && key_mem[s] == k) begin
                r.status = ST_FOUND;
                r.slot = s[SLOT_W-1:0];
                r.holder = hold_mem[s];
                done = 1'b1;
              end
            end
            if (!done) begin
              for (int i = GROUP_SLOTS_DEF - 1; i >= 0; i--) begin
                s = g * GROUP_SLOTS_DEF + i;
                if (ctrl_mem[s] == CTRL_EMPTY) e = s;
              end
              if (first_del < 0)
                for (int i = GROUP_SLOTS_DEF - 1; i >= 0; i--) begin
                  s = g * GROUP_SLOTS_DEF + i;
                  if (ctrl_mem[s] == CTRL_DELETED) first_del = s;
                end
              if (e >= 0) begin
                target = (first_del >= 0) ? first_del : e;
                done = 1'b1;
              end
              g = (g + 1) % NGROUP;
            end
          end
          if (!done && first_del >= 0) target = first_del;
          if (r.status != ST_FOUND && target >= 0) begin
            if (ctrl_mem[target] == CTRL_DELETED) tomb_cnt = tomb_cnt - 1'b1;
            ctrl_mem[target] = {1'b0, h[TAG_W-1:0]};
            key_mem[target] = k;
            hold_mem[target] = hin;
            live_cnt = live_cnt + 1'b1;
            r.status = ST_INSERTED;
            r.slot = target[SLOT_W-1:0];
            r.holder = hin;
          end
        end
      end
    endcase
    r.live = live_cnt;
    return r;
  endfunction

  // Send one request beat and record its expectation at acceptance.
  // valid stays high after the beat; drain() lowers it, the next call only when it idles.
  task automatic send_op(func_e f, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                         logic [KEY_W-1:0] nk, logic [HOLDER_W-1:0] hin);
    table_rsp_t r;
    while (req_idle_en && $urandom_range(99) < 25) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= f;
    req_if.key <= k;
    req_if.hash <= h;
    req_if.new_key <= nk;
    req_if.holder_in <= hin;
    do @(posedge clk_i); while (!req_if.ready);
    r = predict_table(f, k, h, nk, hin);
    expected_rsps.push_back(r);
    if (f == FUNC_INSERT && r.status == ST_INSERTED) begin
      live_keys.push_back(k);
      live_hashes.push_back(h);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (GROUP_COUNT_DEF * 3 + 20) @(posedge clk_i);
  endtask

  task automatic write_occupancy(logic [COUNT_W-1:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    occ_limit = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [55:0] rand56();
    return HASH_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] rand48();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response beat status %0d slot %0d", $time,
                   rsp_if.status, rsp_if.slot);
          errors++;
        end else begin
          table_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.slot !== e.slot) begin
            $display("%0t: slot exp %0d got %0d", $time, e.slot, rsp_if.slot);
            errors++;
          end
          if (rsp_if.holder_out !== e.holder) begin
            $display("%0t: holder exp %h got %h", $time, e.holder, rsp_if.holder_out);
            errors++;
          end
          if (rsp_if.live_count !== e.live) begin
            $display("%0t: live_count exp %0d got %0d", $time, e.live, rsp_if.live_count);
            errors++;
          end
        end
      end
      rsp_if.ready <= !(rsp_stall_en && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    logic [KEY_W-1:0] kmax;
    kmax = '1;
    send_op(FUNC_LOOKUP, 48'h1, 56'h0, '0, '0);
    send_op(FUNC_INSERT, '0, 56'h0, '0, 32'hFFFF_FFFF);   // key zero inserts
    send_op(FUNC_LOOKUP, '0, 56'h0, '0, '0);              // key zero lookup misses
    send_op(FUNC_UPDATE, '0, 56'h0, 48'h5, '0);
    send_op(FUNC_INSERT, kmax, '1, '0, 32'h1234_5678);
    send_op(FUNC_INSERT, kmax, '1, '0, 32'h0);            // present key keeps holder
    send_op(FUNC_LOOKUP, kmax, '1, '0, '0);
    send_op(FUNC_UPDATE, kmax, '1, 48'hABCD, '0);
    send_op(FUNC_LOOKUP, 48'hABCD, '1, '0, '0);
    send_op(FUNC_REMOVE, 48'hABCD, '1, '0, '0);
    send_op(FUNC_REMOVE, 48'hABCD, '1, '0, '0);
    send_op(FUNC_INSERT, 48'h77, 56'h5, '0, 32'hA5A5_A5A5); // lands in an empty slot of its home group
    send_op(FUNC_REMOVE, 48'h77, 56'h5, '0, '0);
    send_op(FUNC_REMOVE, '0, 56'h0, '0, '0);              // last live entry: clear
    send_op(FUNC_LOOKUP, 48'h77, 56'h5, '0, '0);
    live_keys.delete();
    live_hashes.delete();
  endtask

  // Fill one home group past its end to force probe chains and wrap
  task automatic test_overflow();
    for (int i = 0; i < 20; i++)
      send_op(FUNC_INSERT, 48'h100 + i, {49'(NGROUP - 1), 7'(i)}, '0, $urandom());
    for (int i = 0; i < 20; i += 3)
      send_op(FUNC_REMOVE, 48'h100 + i, {49'(NGROUP - 1), 7'(i)}, '0, '0);
    for (int i = 0; i < 20; i++)
      send_op(FUNC_LOOKUP, 48'h100 + i, {49'(NGROUP - 1), 7'(i)}, '0, '0);
  endtask

  task automatic test_occupancy_limit(logic [COUNT_W-1:0] lim, int n);
    write_occupancy(lim);
    for (int i = 0; i < n; i++) send_op(FUNC_INSERT, rand48(), rand56(), '0, $urandom());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      int sel, j;
      func_e f;
      logic [KEY_W-1:0] k;
      logic [HASH_W-1:0] h;
      sel = $urandom_range(99);
      k = rand48();
      h = rand56();
      if ($urandom_range(3) == 0) h[55:13] = '0;     // clear upper hash bits: home group comes from hash[12:7] alone
      if (sel < 40) f = FUNC_INSERT;
      else if (sel < 60) f = FUNC_LOOKUP;
      else if (sel < 75) f = FUNC_UPDATE;
      else f = FUNC_REMOVE;
      if (f != FUNC_INSERT && live_keys.size() != 0 && $urandom_range(9) < 8) begin
        j = $urandom_range(live_keys.size() - 1);
        k = live_keys[j];
        h = live_hashes[j];
        if (f == FUNC_REMOVE || f == FUNC_UPDATE) begin
          live_keys.delete(j);
          live_hashes.delete(j);
        end
      end
      send_op(f, k, h, rand48(), $urandom());
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.func = '0;
    req_if.key = '0;
    req_if.hash = '0;
    req_if.new_key = '0;
    req_if.holder_in = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int i = 0; i < NSLOT; i++) begin
      ctrl_mem[i] = CTRL_EMPTY;
      key_mem[i] = '0;
      hold_mem[i] = '0;
    end
    live_cnt = '0;
    tomb_cnt = '0;
    occ_limit = MAX_OCC_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (GROUP_COUNT_DEF + 10) @(posedge clk_i);

    test_directed();
    test_overflow();
    test_occupancy_limit(11'd0, 3);
    test_occupancy_limit(11'd40, 60);
    test_random(500);
    drain();                                 // sender holds off until all results are in
    rsp_stall_en = 1'b0;
    req_idle_en = 1'b0;
    test_random(300);
    rsp_stall_en = 1'b1;
    req_idle_en = 1'b1;
    test_occupancy_limit(11'd2047, 20);
    test_random(600);
    test_occupancy_limit(MAX_OCC_RESET, 10);
    test_random(400);
    drain();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
